>>> sv/ftfm_pkg.sv
package ftfm_pkg;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	localparam int ADDR_KEY_W = 64;
	localparam int PP_KEY_W   = 40;
	localparam int KEY_W      = ADDR_KEY_W + PP_KEY_W;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;      // latch the incoming word and build its key
		logic issue;     // read the key store at the scan index
		logic take_hit;  // record the compared entry as the hit slot
		logic fetch;     // read the counter store at the hit slot
		logic update;    // hit: update the entry and register the result
		logic alloc;     // miss: allocate (or report a lone flow)
	} ftfm_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic empty;     // no entry in use
		logic more;      // scan index still below the fill count
		logic hit;       // registered key read matches the search key
		logic cmp_last;  // registered key read is the last entry in use
	} ftfm_status_t;

	// one stored key
	typedef struct packed {
		logic [ADDR_KEY_W-1:0] addrs;
		logic [PP_KEY_W-1:0]   ports_proto;
	} ftfm_key_t;

	// one stored set of counters
	typedef struct packed {
		logic [31:0] start;
		logic [31:0] packets;
		logic [39:0] bytes;
		logic [5:0]  flags;
		logic [31:0] sequence_no;
	} ftfm_entry_t;

endpackage

>>> sv/ftfm_ctrl.sv
module ftfm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  ftfm_pkg::ftfm_status_t st,
	output ftfm_pkg::ftfm_cmd_t    cmd,
	output logic                  busy,
	output logic                  done
);
	import ftfm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_FETCH,
		S_UPDATE,
		S_ALLOC
	} state_t;

	state_t state_q, state_d;
	logic   busy_q, done_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = st.empty ? S_ALLOC : S_SCAN;
				end
			end
			S_SCAN: begin
				priority if (st.hit) begin
					state_d = S_FETCH;
				end else if (st.cmp_last) begin
					state_d = S_ALLOC;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_FETCH:  state_d = S_UPDATE;
			S_UPDATE: state_d = S_IDLE;
			S_ALLOC:  state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// command decode
	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == S_IDLE) && start;
		cmd.issue    = (state_q == S_SCAN) && st.more;
		cmd.take_hit = (state_q == S_SCAN) && st.hit;
		cmd.fetch    = (state_q == S_FETCH);
		cmd.update   = (state_q == S_UPDATE);
		cmd.alloc    = (state_q == S_ALLOC);
	end

	// state and registered handshake outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
			done_q  <= (state_q == S_UPDATE) || (state_q == S_ALLOC);
		end
	end

	assign busy = busy_q;
	assign done = done_q;

	// an accepted word keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	// result strobe lasts a single cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	// a match during the scan goes straight to the counter read
	a_hit_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) && st.hit |=> (state_q == S_FETCH))
		else $error("hit did not lead to counter fetch");

	// busy follows the state machine
	a_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		busy == (state_q != S_IDLE))
		else $error("busy out of step with controller state");

endmodule

>>> sv/ftfm_datapath.sv
module ftfm_datapath #(
	parameter int FLOW_ENTRIES = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ftfm_pkg::ftfm_cmd_t    cmd,
	output ftfm_pkg::ftfm_status_t st,
	input  logic                  cfg_wr_en,
	input  logic [47:0]           cfg_wr_data,
	input  logic [31:0]           source_ip,
	input  logic [31:0]           dest_ip,
	input  logic [7:0]            protocol,
	input  logic [15:0]           total_length,
	input  logic [15:0]           source_port,
	input  logic [15:0]           dest_port,
	input  logic [31:0]           tcp_sequence,
	input  logic [5:0]            tcp_flag_bits,
	input  logic [31:0]           arrival_seconds,
	input  logic [47:0]           source_mac,
	output logic [7:0]            flow_slot,
	output logic                  new_flow,
	output logic                  table_full,
	output logic [31:0]           start_seconds,
	output logic [31:0]           last_seconds,
	output logic [31:0]           packet_total,
	output logic [39:0]           byte_total,
	output logic                  boundary,
	output logic                  flags_repeated,
	output logic                  sequence_repeated
);
	import ftfm_pkg::*;

	localparam int IDX_W = $clog2(FLOW_ENTRIES);
	localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);
	localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(FLOW_ENTRIES);

	// stores
	ftfm_key_t   key_mem  [FLOW_ENTRIES];
	ftfm_entry_t data_mem [FLOW_ENTRIES];

	logic [47:0] router_mac_q;

	// latched word
	ftfm_key_t   key_q;
	logic        is_tcp_q;
	logic [15:0] len_q;
	logic [31:0] seq_q;
	logic [5:0]  flags_q;
	logic [31:0] now_q;
	logic [47:0] smac_q;

	// fill count: entries in use are always 0 .. fill-1
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] scan_idx_q;
	logic [CNT_W-1:0] rd_idx_s1;
	logic             rd_valid_s1;
	ftfm_key_t        rd_key_s1;
	logic [IDX_W-1:0] slot_q;
	ftfm_entry_t      rd_entry_q;

	logic             has_ports;
	ftfm_key_t        key_d;
	logic             is_full;
	logic             match;
	ftfm_entry_t      hit_entry;
	ftfm_entry_t      new_entry;
	logic [40:0]      byte_sum;
	logic [IDX_W+7:0] slot_wide;

	// key of the incoming word
	always_comb begin
		has_ports = (protocol == PROTO_TCP) || (protocol == PROTO_UDP);
		key_d.addrs = {source_ip, dest_ip};
		key_d.ports_proto = has_ports ? {source_port, dest_port, protocol}
		                              : {32'd0, protocol};
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			router_mac_q <= '1;
		end else if (cfg_wr_en) begin
			router_mac_q <= cfg_wr_data;
		end
	end

	// input latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q    <= key_d;
			is_tcp_q <= (protocol == PROTO_TCP);
			len_q    <= total_length;
			seq_q    <= tcp_sequence;
			flags_q  <= tcp_flag_bits;
			now_q    <= arrival_seconds;
			smac_q   <= source_mac;
		end
	end

	// scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			scan_idx_q  <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.issue;
			if (cmd.load) begin
				scan_idx_q <= '0;
			end else if (cmd.issue) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (cmd.alloc && !is_full) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// key store
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rd_key_s1 <= key_mem[scan_idx_q[IDX_W-1:0]];
			rd_idx_s1 <= scan_idx_q;
		end
		if (cmd.alloc && !is_full) begin
			key_mem[fill_q[IDX_W-1:0]] <= key_q;
		end
	end

	assign is_full  = (fill_q == ENTRIES_C);
	assign match    = rd_valid_s1 && (rd_key_s1 == key_q);
	assign st.empty = (fill_q == '0);
	assign st.more  = (scan_idx_q < fill_q);
	assign st.hit   = match;
	assign st.cmp_last = rd_valid_s1 && (rd_idx_s1 == fill_q - 1'b1);

	// hit: saturating counters, last flags and sequence
	always_comb begin
		byte_sum = {1'b0, rd_entry_q.bytes} + {25'd0, len_q};
		hit_entry.start       = rd_entry_q.start;
		hit_entry.packets     = (rd_entry_q.packets == '1) ? rd_entry_q.packets
		                                                   : rd_entry_q.packets + 1'b1;
		hit_entry.bytes       = byte_sum[40] ? '1 : byte_sum[39:0];
		hit_entry.flags       = is_tcp_q ? flags_q : 6'd0;
		hit_entry.sequence_no = is_tcp_q ? seq_q : 32'd0;
	end

	// miss: a fresh flow of one packet
	always_comb begin
		new_entry.start       = now_q;
		new_entry.packets     = 32'd1;
		new_entry.bytes       = {24'd0, len_q};
		new_entry.flags       = is_tcp_q ? flags_q : 6'd0;
		new_entry.sequence_no = is_tcp_q ? seq_q : 32'd0;
	end

	// counter store
	always_ff @(posedge clk) begin
		if (cmd.take_hit) begin
			slot_q <= rd_idx_s1[IDX_W-1:0];
		end
		if (cmd.fetch) begin
			rd_entry_q <= data_mem[slot_q];
		end
		if (cmd.update) begin
			data_mem[slot_q] <= hit_entry;
		end else if (cmd.alloc && !is_full) begin
			data_mem[fill_q[IDX_W-1:0]] <= new_entry;
		end
	end

	// result word
	always_comb begin
		if (cmd.update) begin
			slot_wide = {8'd0, slot_q};
		end else if (is_full) begin
			slot_wide = '0;
		end else begin
			slot_wide = {8'd0, fill_q[IDX_W-1:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update || cmd.alloc) begin
			flow_slot    <= slot_wide[7:0];
			last_seconds <= now_q;
			boundary     <= (smac_q != router_mac_q);
			if (cmd.update) begin
				new_flow          <= 1'b0;
				table_full        <= 1'b0;
				start_seconds     <= hit_entry.start;
				packet_total      <= hit_entry.packets;
				byte_total        <= hit_entry.bytes;
				flags_repeated    <= is_tcp_q && (rd_entry_q.flags == flags_q);
				sequence_repeated <= is_tcp_q && (rd_entry_q.sequence_no == seq_q);
			end else begin
				new_flow          <= 1'b1;
				table_full        <= is_full;
				start_seconds     <= new_entry.start;
				packet_total      <= new_entry.packets;
				byte_total        <= new_entry.bytes;
				flags_repeated    <= 1'b0;
				sequence_repeated <= 1'b0;
			end
		end
	end

	// fill count never passes the store depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= ENTRIES_C)
		else $error("fill count beyond store depth");

	// a compared read always lies among the entries in use
	a_read_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> (rd_idx_s1 < fill_q))
		else $error("key read outside the entries in use");

	// allocation adds exactly one entry unless the store is full
	a_alloc_grow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc && !is_full |=> fill_q == $past(fill_q) + 1'b1)
		else $error("allocation did not grow the fill count");

endmodule

>>> sv/five_tuple_flow_metering.sv
// Flow metering on parsed packet headers.
// Input: drive the header fields and raise start; the word is taken at a
// clock edge where start is high and busy is low. busy stays high while the
// flow store is searched and updated.
// Output: one result per word, valid for a single cycle while done is high.
// The receiver cannot hold results off; done drops in the following cycle.
// The key store is scanned one entry per cycle through its single read port,
// over the entries in use (at most FLOW_ENTRIES); a hit then reads and
// updates its counters, a miss allocates. busy falls in the cycle done is
// shown, so a new word can be taken then; no new word is taken while busy.
// Entries are never freed and a miss takes the next one, so the store is
// tracked by a fill count; reset empties it at once and sets router_mac to
// all ones. cfg_wr_en/cfg_wr_data write router_mac; the user must do so
// only while idle, which the block itself does not enforce.
// With the store full, a miss returns a lone flow with table_full set.
module five_tuple_flow_metering #(
	parameter int FLOW_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [47:0] cfg_wr_data,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] source_ip,
	input  logic [31:0] dest_ip,
	input  logic [7:0]  protocol,
	input  logic [15:0] total_length,
	input  logic [15:0] source_port,
	input  logic [15:0] dest_port,
	input  logic [31:0] tcp_sequence,
	input  logic [5:0]  tcp_flag_bits,
	input  logic [31:0] arrival_seconds,
	input  logic [47:0] source_mac,
	output logic        done,
	output logic [7:0]  flow_slot,
	output logic        new_flow,
	output logic        table_full,
	output logic [31:0] start_seconds,
	output logic [31:0] last_seconds,
	output logic [31:0] packet_total,
	output logic [39:0] byte_total,
	output logic        boundary,
	output logic        flags_repeated,
	output logic        sequence_repeated
);
	import ftfm_pkg::*;

	ftfm_cmd_t    cmd;
	ftfm_status_t st;

	ftfm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ftfm_datapath #(
		.FLOW_ENTRIES (FLOW_ENTRIES)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.st                (st),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_wr_data       (cfg_wr_data),
		.source_ip         (source_ip),
		.dest_ip           (dest_ip),
		.protocol          (protocol),
		.total_length      (total_length),
		.source_port       (source_port),
		.dest_port         (dest_port),
		.tcp_sequence      (tcp_sequence),
		.tcp_flag_bits     (tcp_flag_bits),
		.arrival_seconds   (arrival_seconds),
		.source_mac        (source_mac),
		.flow_slot         (flow_slot),
		.new_flow          (new_flow),
		.table_full        (table_full),
		.start_seconds     (start_seconds),
		.last_seconds      (last_seconds),
		.packet_total      (packet_total),
		.byte_total        (byte_total),
		.boundary          (boundary),
		.flags_repeated    (flags_repeated),
		.sequence_repeated (sequence_repeated)
	);

endmodule

>>> test/flow_meter_checker.sv
// Watches the header and result channels of the flow meter, keeps its own
// copy of the flow store and the router MAC, and compares every result word
// with the oldest prediction.
module flow_meter_checker #(
	parameter int ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [47:0] cfg_wr_data,
	input  logic        start,
	input  logic        busy,
	input  logic [31:0] source_ip,
	input  logic [31:0] dest_ip,
	input  logic [7:0]  protocol,
	input  logic [15:0] total_length,
	input  logic [15:0] source_port,
	input  logic [15:0] dest_port,
	input  logic [31:0] tcp_sequence,
	input  logic [5:0]  tcp_flag_bits,
	input  logic [31:0] arrival_seconds,
	input  logic [47:0] source_mac,
	input  logic        done,
	input  logic [7:0]  flow_slot,
	input  logic        new_flow,
	input  logic        table_full,
	input  logic [31:0] start_seconds,
	input  logic [31:0] last_seconds,
	input  logic [31:0] packet_total,
	input  logic [39:0] byte_total,
	input  logic        boundary,
	input  logic        flags_repeated,
	input  logic        sequence_repeated,
	output int          mismatch_count,
	output int          words_pending,
	output int          results_checked,
	output int          hits_seen,
	output int          full_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	import ftfm_pkg::*;

	typedef struct packed {
		logic [7:0]  slot;
		logic        new_flow;
		logic        full;
		logic [31:0] first_s;
		logic [31:0] last_s;
		logic [31:0] packets;
		logic [39:0] bytes;
		logic        boundary;
		logic        frep;
		logic        srep;
	} meter_result_t;

	meter_result_t meter_q[$];
	meter_result_t want;
	logic          in_use  [ENTRIES];
	ftfm_key_t     key_copy[ENTRIES];
	ftfm_entry_t   ctr_copy[ENTRIES];
	logic [47:0]   mac_copy;
	int            errs, n_checked, n_hit, n_full;

	// meter one header against the local flow store, updating it as the block does
	function automatic meter_result_t meter_header();
		meter_result_t r;
		ftfm_key_t     k;
		logic          is_tcp, has_ports, hit, have_free;
		int            slot, free_slot;
		logic [40:0]   sum;
		is_tcp    = (protocol == PROTO_TCP);
		has_ports = is_tcp || (protocol == PROTO_UDP);
		k.addrs = {source_ip, dest_ip};
		k.ports_proto = has_ports ? {source_port, dest_port, protocol} : {32'd0, protocol};
		hit = 1'b0;
		have_free = 1'b0;
		slot = 0;
		free_slot = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (in_use[i]) begin
				if (!hit && key_copy[i] == k) begin
					hit = 1'b1;
					slot = i;
				end
			end else if (!have_free) begin
				have_free = 1'b1;
				free_slot = i;
			end
		end
		r = '0;
		r.last_s   = arrival_seconds;
		r.first_s  = arrival_seconds;
		r.packets  = 32'd1;
		r.bytes    = {24'd0, total_length};
		r.boundary = (source_mac != mac_copy);
		if (hit) begin
			n_hit++;
			r.first_s = ctr_copy[slot].start;
			r.packets = ctr_copy[slot].packets;
			if (r.packets != '1)
				r.packets = r.packets + 32'd1;
			sum = {1'b0, ctr_copy[slot].bytes} + {25'd0, total_length};
			r.bytes = sum[40] ? '1 : sum[39:0];
			if (is_tcp) begin
				r.frep = (ctr_copy[slot].flags == tcp_flag_bits);
				r.srep = (ctr_copy[slot].sequence_no == tcp_sequence);
			end
		end else if (have_free) begin
			slot = free_slot;
			r.new_flow = 1'b1;
			in_use[slot] = 1'b1;
			key_copy[slot] = k;
			ctr_copy[slot].start = arrival_seconds;
		end else begin
			// store full: lone flow, nothing kept
			n_full++;
			slot = 0;
			r.new_flow = 1'b1;
			r.full = 1'b1;
		end
		if (!r.full) begin
			ctr_copy[slot].packets     = r.packets;
			ctr_copy[slot].bytes       = r.bytes;
			ctr_copy[slot].flags       = is_tcp ? tcp_flag_bits : 6'd0;
			ctr_copy[slot].sequence_no = is_tcp ? tcp_sequence : 32'd0;
		end
		r.slot = slot[7:0];
		return r;
	endfunction

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
			errs++;
		end
	endtask

	// result words are compared before the header of the same edge is metered
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meter_q.delete();
			mac_copy = '1;
			for (int i = 0; i < ENTRIES; i++) begin
				in_use[i] = 1'b0;
				key_copy[i] = '0;
				ctr_copy[i] = '0;
			end
			errs = 0;
			n_checked = 0;
			n_hit = 0;
			n_full = 0;
		end else begin
			if (cfg_wr_en)
				mac_copy = cfg_wr_data;
			if (done) begin
				if (meter_q.size() == 0) begin
					$error("result word with no header waiting for it");
					errs++;
				end else begin
					want = meter_q.pop_front();
					check_field("flow_slot", 64'(want.slot), 64'(flow_slot));
					check_field("new_flow", 64'(want.new_flow), 64'(new_flow));
					check_field("table_full", 64'(want.full), 64'(table_full));
					check_field("start_seconds", 64'(want.first_s), 64'(start_seconds));
					check_field("last_seconds", 64'(want.last_s), 64'(last_seconds));
					check_field("packet_total", 64'(want.packets), 64'(packet_total));
					check_field("byte_total", 64'(want.bytes), 64'(byte_total));
					check_field("boundary", 64'(want.boundary), 64'(boundary));
					check_field("flags_repeated", 64'(want.frep), 64'(flags_repeated));
					check_field("sequence_repeated", 64'(want.srep),
						64'(sequence_repeated));
					n_checked++;
				end
			end
			if (start && !busy)
				meter_q.push_back(meter_header());
		end
		mismatch_count  <= errs;
		words_pending   <= meter_q.size();
		results_checked <= n_checked;
		hits_seen       <= n_hit;
		full_seen       <= n_full;
	end

endmodule

>>> test/tb_five_tuple_flow_metering.sv
module tb_five_tuple_flow_metering;
	timeunit 1ns;
	timeprecision 1ps;

	import ftfm_pkg::*;

	localparam int FLOW_ENTRIES = 256;

	typedef struct packed {
		logic [31:0] sip;
		logic [31:0] dip;
		logic [7:0]  proto;
		logic [15:0] len;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [31:0] seq;
		logic [5:0]  flags;
		logic [31:0] now;
		logic [47:0] smac;
	} pkt_hdr_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [47:0] cfg_wr_data;
	logic        start;
	logic        busy;
	logic [31:0] source_ip;
	logic [31:0] dest_ip;
	logic [7:0]  protocol;
	logic [15:0] total_length;
	logic [15:0] source_port;
	logic [15:0] dest_port;
	logic [31:0] tcp_sequence;
	logic [5:0]  tcp_flag_bits;
	logic [31:0] arrival_seconds;
	logic [47:0] source_mac;
	logic        done;
	logic [7:0]  flow_slot;
	logic        new_flow;
	logic        table_full;
	logic [31:0] start_seconds;
	logic [31:0] last_seconds;
	logic [31:0] packet_total;
	logic [39:0] byte_total;
	logic        boundary;
	logic        flags_repeated;
	logic        sequence_repeated;

	int mismatch_count, words_pending, results_checked, hits_seen, full_seen;

	pkt_hdr_t    flow_pool[$];
	logic [47:0] cur_mac;
	logic [31:0] clock_s;
	int          words_sent, mac_settings, burst_left;

	always #10 clk = ~clk;

	five_tuple_flow_metering #(
		.FLOW_ENTRIES(FLOW_ENTRIES)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.start(start), .busy(busy),
		.source_ip(source_ip), .dest_ip(dest_ip), .protocol(protocol),
		.total_length(total_length), .source_port(source_port), .dest_port(dest_port),
		.tcp_sequence(tcp_sequence), .tcp_flag_bits(tcp_flag_bits),
		.arrival_seconds(arrival_seconds), .source_mac(source_mac),
		.done(done), .flow_slot(flow_slot), .new_flow(new_flow), .table_full(table_full),
		.start_seconds(start_seconds), .last_seconds(last_seconds),
		.packet_total(packet_total), .byte_total(byte_total), .boundary(boundary),
		.flags_repeated(flags_repeated), .sequence_repeated(sequence_repeated)
	);

	flow_meter_checker #(
		.ENTRIES(FLOW_ENTRIES)
	) chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.start(start), .busy(busy),
		.source_ip(source_ip), .dest_ip(dest_ip), .protocol(protocol),
		.total_length(total_length), .source_port(source_port), .dest_port(dest_port),
		.tcp_sequence(tcp_sequence), .tcp_flag_bits(tcp_flag_bits),
		.arrival_seconds(arrival_seconds), .source_mac(source_mac),
		.done(done), .flow_slot(flow_slot), .new_flow(new_flow), .table_full(table_full),
		.start_seconds(start_seconds), .last_seconds(last_seconds),
		.packet_total(packet_total), .byte_total(byte_total), .boundary(boundary),
		.flags_repeated(flags_repeated), .sequence_repeated(sequence_repeated),
		.mismatch_count(mismatch_count), .words_pending(words_pending),
		.results_checked(results_checked), .hits_seen(hits_seen), .full_seen(full_seen)
	);

	function automatic pkt_hdr_t mk(logic [31:0] sip, logic [31:0] dip, logic [7:0] proto,
			logic [15:0] len, logic [15:0] sport, logic [15:0] dport, logic [31:0] seq,
			logic [5:0] flags, logic [31:0] now, logic [47:0] smac);
		pkt_hdr_t h;
		h = '{sip, dip, proto, len, sport, dport, seq, flags, now, smac};
		return h;
	endfunction

	// mostly back to back or short gaps, now and then a long one or a burst
	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			burst_left = $urandom_range(20, 40);
			return 0;
		end
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 20);
		return $urandom_range(50, 300);
	endfunction

	function automatic logic [7:0] pick_proto();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return PROTO_TCP;
		if (r < 70)
			return PROTO_UDP;
		if (r < 80)
			return 8'd1;
		if (r < 85)
			return 8'd0;
		if (r < 90)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	function automatic logic [15:0] pick_len();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'd0;
		if (r == 1)
			return 16'hFFFF;
		return 16'($urandom);
	endfunction

	function automatic logic [47:0] pick_mac();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return cur_mac;
		if (r < 65)
			return cur_mac ^ (48'd1 << $urandom_range(0, 47));
		if (r < 90)
			return {16'($urandom), 32'($urandom)};
		return r[0] ? '1 : '0;
	endfunction

	// random header: revisits of known flows, near misses and fresh flows
	function automatic pkt_hdr_t random_header();
		pkt_hdr_t h, p;
		int       r, idx;
		if ($urandom_range(0, 19) == 0)
			clock_s = $urandom;
		else
			clock_s = clock_s + $urandom_range(0, 2);
		h = mk($urandom, $urandom, pick_proto(), pick_len(), 16'($urandom), 16'($urandom),
			$urandom, 6'($urandom), clock_s, pick_mac());
		r = $urandom_range(0, 99);
		idx = (flow_pool.size() > 0) ? $urandom_range(0, flow_pool.size() - 1) : 0;
		if (flow_pool.size() > 0 && r < 50) begin
			p = flow_pool[idx];
			h.sip = p.sip;
			h.dip = p.dip;
			h.proto = p.proto;
			// ports only matter for TCP and UDP; elsewhere they stay random
			if (p.proto == PROTO_TCP || p.proto == PROTO_UDP) begin
				h.sport = p.sport;
				h.dport = p.dport;
			end
			if (p.proto == PROTO_TCP) begin
				if ($urandom_range(0, 2) == 0)
					h.flags = p.flags;
				if ($urandom_range(0, 2) == 0)
					h.seq = p.seq;
			end
			flow_pool[idx] = h;
		end else if (flow_pool.size() > 0 && r < 60) begin
			// one bit of the addresses, protocol or ports away from a known flow
			p = flow_pool[idx];
			h.sip = p.sip;
			h.dip = p.dip;
			h.proto = p.proto;
			h.sport = p.sport;
			h.dport = p.dport;
			case ($urandom_range(0, 4))
				0: h.sip[$urandom_range(0, 31)] ^= 1'b1;
				1: h.dip[$urandom_range(0, 31)] ^= 1'b1;
				2: h.proto[$urandom_range(0, 7)] ^= 1'b1;
				3: h.sport[$urandom_range(0, 15)] ^= 1'b1;
				default: h.dport[$urandom_range(0, 15)] ^= 1'b1;
			endcase
			flow_pool.push_back(h);
		end else begin
			flow_pool.push_back(h);
		end
		return h;
	endfunction

	// present one header word; start stays high across back-to-back words
	task automatic send_header(pkt_hdr_t h);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start           <= 1'b1;
		source_ip       <= h.sip;
		dest_ip         <= h.dip;
		protocol        <= h.proto;
		total_length    <= h.len;
		source_port     <= h.sport;
		dest_port       <= h.dport;
		tcp_sequence    <= h.seq;
		tcp_flag_bits   <= h.flags;
		arrival_seconds <= h.now;
		source_mac      <= h.smac;
		do
			@(posedge clk);
		while (busy);
		words_sent++;
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (words_pending != 0 || busy)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_mac(logic [47:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_mac = v;
		mac_settings++;
	endtask

	task automatic random_phase(int n);
		repeat (n) send_header(random_header());
	endtask

	// stimulus
	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		start = 1'b0;
		source_ip = '0;
		dest_ip = '0;
		protocol = '0;
		total_length = '0;
		source_port = '0;
		dest_port = '0;
		tcp_sequence = '0;
		tcp_flag_bits = '0;
		arrival_seconds = '0;
		source_mac = '0;
		cur_mac = '1;
		clock_s = 32'd1000;
		words_sent = 0;
		mac_settings = 1;
		burst_left = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, router MAC at its reset value
		send_header(mk('0, '0, PROTO_TCP, 16'd0, 16'd0, 16'd0, '0, 6'd0, '0, '1));
		send_header(mk('0, '0, PROTO_TCP, 16'd0, 16'd0, 16'd0, '0, 6'd0, 32'd1, '1));
		send_header(mk('0, '0, PROTO_TCP, 16'hFFFF, 16'd0, 16'd0, '1, 6'h3F, 32'd5, '1));
		send_header(mk('0, '0, PROTO_TCP, 16'd100, 16'd0, 16'd0, 32'h1234_5678, 6'h3F,
			32'd6, '0));
		send_header(mk('1, '1, PROTO_UDP, 16'hFFFF, 16'hFFFF, 16'hFFFF, '1, 6'h3F, '1, '1));
		send_header(mk('1, '1, PROTO_UDP, 16'hFFFF, 16'hFFFF, 16'hFFFF, '1, 6'h3F, '1, '1));
		send_header(mk('1, '1, PROTO_TCP, 16'd1, 16'hFFFF, 16'hFFFF, '0, 6'h12, 32'd7, '1));
		// ports ignored outside TCP and UDP
		send_header(mk(32'hC0A8_0001, 32'h0A00_0001, 8'd1, 16'd64, 16'd1234, 16'd80,
			32'd55, 6'h01, 32'd8, 48'h0000_0000_0001));
		send_header(mk(32'hC0A8_0001, 32'h0A00_0001, 8'd1, 16'd64, 16'hFFFF, 16'd0,
			32'd56, 6'h01, 32'd9, 48'h8000_0000_0000));
		send_header(mk('0, '0, 8'd0, 16'd20, 16'hFFFF, 16'hFFFF, '1, 6'h3F, 32'd10, '1));
		send_header(mk('1, '0, 8'hFF, 16'd20, 16'h5555, 16'hAAAA, '0, 6'h2A, 32'd11, '1));
		send_header(mk('0, '0, PROTO_UDP, 16'd28, 16'd0, 16'd0, '0, 6'd0, 32'd12, '1));
		send_header(mk('0, '0, PROTO_TCP, 16'd40, 16'h8000, 16'h0001, 32'hAAAA_5555, 6'h15,
			32'd13, '1));
		send_header(mk('0, '0, PROTO_TCP, 16'd40, 16'h8000, 16'h0001, 32'hAAAA_5555, 6'h15,
			32'd14, '1));
		wait_idle();

		// router MAC all zeros
		write_mac('0);
		send_header(mk(32'h0102_0304, 32'h0506_0708, PROTO_UDP, 16'd90, 16'd53, 16'd53, '0,
			6'd0, 32'd20, '0));
		send_header(mk(32'h0102_0304, 32'h0506_0708, PROTO_UDP, 16'd90, 16'd53, 16'd53, '0,
			6'd0, 32'd21, 48'h8000_0000_0000));
		send_header(mk(32'h0102_0304, 32'h0506_0708, PROTO_UDP, 16'd90, 16'd53, 16'd53, '0,
			6'd0, 32'd22, '1));
		wait_idle();

		// random traffic; the store fills up during the later phases
		write_mac({16'($urandom), 32'($urandom)});
		random_phase(250);
		wait_idle();
		write_mac({16'($urandom), 32'($urandom)});
		random_phase(250);
		wait_idle();
		write_mac('1);
		random_phase(200);
		wait_idle();
		repeat (20) @(posedge clk);

		$display("Sent %0d header words, checked %0d results: %0d hits, %0d with the store full",
			words_sent, results_checked, hits_seen, full_seen);
		$display("Router MAC settings used: %0d", mac_settings);
		if (mismatch_count == 0 && words_pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#40_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

>>> five_tuple_flow_metering.f
sv/ftfm_pkg.sv
sv/ftfm_ctrl.sv
sv/ftfm_datapath.sv
sv/five_tuple_flow_metering.sv
test/flow_meter_checker.sv
test/tb_five_tuple_flow_metering.sv
